[hw/rtl/hdcp_pkg.sv]
// ---------------------------------------------------------------------------
// hdcp_pkg: shared types and microcode for the halfband chain planner
// holds the stage mode codes, the control word layout and the program rom
// ---------------------------------------------------------------------------
package hdcp_pkg;

  localparam int RATE_W = 27;
  localparam int IDX_W  = 6;
  localparam int OFS_W  = 59;
  localparam int STEP_W = 3;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_LOWER  = 2'd1,
    MODE_UPPER  = 2'd2,
    MODE_CENTER = 2'd3
  } mode_t;

  // outcome of one halving test
  typedef struct packed {
    logic  hit;
    mode_t mode;
  } fit_t;

  typedef enum logic [1:0] {
    ALU_NONE = 2'd0,
    ALU_MID  = 2'd1,
    ALU_OFS  = 2'd2
  } alu_op_t;

  typedef enum logic [1:0] {
    EMIT_NONE  = 2'd0,
    EMIT_LAST  = 2'd1,
    EMIT_ABORT = 2'd2
  } emit_t;

  // sequencing condition of a step
  typedef enum logic [2:0] {
    COND_JUMP  = 3'd0,  // go to target
    COND_IN    = 3'd1,  // hold until a request arrives, then advance
    COND_RATE0 = 3'd2,  // go to target on zero rate, else advance
    COND_TEST  = 3'd3,  // repeat while stages keep fitting, else advance
    COND_SLOT  = 3'd4   // hold until the output slot is free, then go to target
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_INIT  = 3'd1;
  localparam step_t STEP_TEST  = 3'd2;
  localparam step_t STEP_MID   = 3'd3;
  localparam step_t STEP_OFS   = 3'd4;
  localparam step_t STEP_LAST  = 3'd5;
  localparam step_t STEP_ABORT = 3'd6;

  typedef struct packed {
    logic    take_in;
    logic    init_load;
    logic    test_en;
    alu_op_t alu;
    emit_t   emit;
    cond_t   cond;
    step_t   tgt;
  } ctrl_t;

  function automatic ctrl_t hdcp_ucode(input step_t step);
    ctrl_t w;
    w = '{take_in: 1'b0, init_load: 1'b0, test_en: 1'b0, alu: ALU_NONE,
          emit: EMIT_NONE, cond: COND_JUMP, tgt: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = COND_IN;
      end
      STEP_INIT: begin
        w.init_load = 1'b1;
        w.cond      = COND_RATE0;
        w.tgt       = STEP_ABORT;
      end
      STEP_TEST: begin
        w.test_en = 1'b1;
        w.cond    = COND_TEST;
      end
      STEP_MID: begin
        w.alu = ALU_MID;
        w.tgt = STEP_OFS;
      end
      STEP_OFS: begin
        w.alu = ALU_OFS;
        w.tgt = STEP_LAST;
      end
      STEP_LAST: begin
        w.emit = EMIT_LAST;
        w.cond = COND_SLOT;
        w.tgt  = STEP_IDLE;
      end
      STEP_ABORT: begin
        w.emit = EMIT_ABORT;
        w.cond = COND_SLOT;
        w.tgt  = STEP_IDLE;
      end
      default: begin
        w.tgt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/hdcp_halver.sv]
// ---------------------------------------------------------------------------
// hdcp_halver: one halving test of the signal band
// tries lower, upper and center half in parallel and picks the first fit
// ---------------------------------------------------------------------------
module hdcp_halver import hdcp_pkg::*; #(
  parameter int VAL_W = 61
) (
  input  logic signed [VAL_W-1:0] band_lo,
  input  logic signed [VAL_W-1:0] band_hi,
  input  logic        [VAL_W-1:0] band_bw,
  input  logic signed [VAL_W-1:0] chan_lo,
  input  logic signed [VAL_W-1:0] chan_hi,
  input  logic                    chan_ok,
  output fit_t                    fit,
  output logic signed [VAL_W-1:0] new_lo,
  output logic signed [VAL_W-1:0] new_hi,
  output logic        [VAL_W-1:0] new_bw
);

  logic        [VAL_W-1:0] half;
  logic        [VAL_W-1:0] quarter;
  logic signed [VAL_W-1:0] lo_half;
  logic signed [VAL_W-1:0] hi_half;
  logic signed [VAL_W-1:0] lo_qtr;
  logic signed [VAL_W-1:0] hi_qtr;
  logic                    fit_lower;
  logic                    fit_upper;
  logic                    fit_center;

  // band width is never negative, so plain shifts give the floor
  assign half    = band_bw >> 1;
  assign quarter = band_bw >> 2;
  assign lo_half = band_lo + $signed(half);
  assign hi_half = band_hi - $signed(half);
  assign lo_qtr  = band_lo + $signed(quarter);
  assign hi_qtr  = band_hi - $signed(quarter);

  // candidate halves are non-empty exactly when half (or the width) is nonzero
  assign fit_lower  = chan_ok && (half != '0) && (band_lo <= chan_lo) && (lo_half >= chan_hi);
  assign fit_upper  = chan_ok && (half != '0) && (hi_half <= chan_lo) && (band_hi >= chan_hi);
  assign fit_center = chan_ok && (band_bw != '0) && (lo_qtr <= chan_lo) && (hi_qtr >= chan_hi);

  always_comb begin
    fit    = '{hit: 1'b0, mode: MODE_NONE};
    new_lo = band_lo;
    new_hi = band_hi;
    new_bw = band_bw;
    if (fit_lower) begin
      fit    = '{hit: 1'b1, mode: MODE_LOWER};
      new_hi = lo_half;
      new_bw = half;
    end else if (fit_upper) begin
      fit    = '{hit: 1'b1, mode: MODE_UPPER};
      new_lo = hi_half;
      new_bw = half;
    end else if (fit_center) begin
      fit    = '{hit: 1'b1, mode: MODE_CENTER};
      new_lo = lo_qtr;
      new_hi = hi_qtr;
      new_bw = band_bw - (quarter << 1);
    end
  end

endmodule

[hw/rtl/halfband_decimation_chain_planner.sv]
// ---------------------------------------------------------------------------
// halfband_decimation_chain_planner: plans a cascade of halfband stages
// microcoded sequencer over a fixed-point band datapath; one result per stage
// ---------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in_     | in_valid / in_stall | input_rate, requested_rate, requested_center
//  out_    | out_valid/out_stall | stage_mode, stage_index, is_last, aborted,
//          |                     | offset_q32, output_rate
//
//  a request passes an accept step, a setup step, one halving test per cycle
//  while the output slot is free, two offset steps (midpoint, then offset)
//  and a step that loads the last result, plus any waits on out_stall; a zero
//  rate goes from the setup step straight to the abort step
//  the halving test (three candidate halves compared at once) sets the pace
//  one request is planned at a time; in_stall is high outside the idle step
//  out_stall only holds the output register; the sequencer waits on it when
//  a new result is ready and the register is still occupied
//  synchronous active-low reset clears the step counter and the output valid
//
module halfband_decimation_chain_planner import hdcp_pkg::*; #(
  parameter int MAX_STAGES = 32,
  parameter int FRAC_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RATE_W-1:0]        in_input_rate,
  input  logic [RATE_W-1:0]        in_requested_rate,
  input  logic signed [RATE_W-1:0] in_requested_center,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_stage_mode,
  output logic [IDX_W-1:0]         out_stage_index,
  output logic                     out_is_last,
  output logic                     out_aborted,
  output logic signed [OFS_W-1:0]  out_offset_q32,
  output logic [RATE_W-1:0]        out_output_rate
);

  // band values span 28 integer bits plus sign above the fraction
  localparam int VAL_W = FRAC_BITS + RATE_W + 2;

  // sequencer
  step_t step_r, step_nxt;
  ctrl_t ctrl;

  // captured request
  logic [RATE_W-1:0]        rate_r;
  logic [RATE_W-2:0]        req_half_r;
  logic signed [RATE_W-1:0] cen_r;

  // band datapath
  logic signed [VAL_W-1:0] lo_r, hi_r, clo_r, chi_r, tmp_r;
  logic        [VAL_W-1:0] bw_r;
  logic                    chan_ok_r;
  logic [IDX_W-1:0]        n_r;
  mode_t                   pend_mode_r;

  // halver results
  fit_t                    fit;
  logic signed [VAL_W-1:0] new_lo, new_hi;
  logic        [VAL_W-1:0] new_bw;

  // setup values
  logic signed [VAL_W-1:0]  rate_half_q;
  logic signed [RATE_W:0]   chan_lo_i, chan_hi_i;
  logic signed [VAL_W-1:0]  cen_q;
  logic signed [63:0]       ofs_ext;

  // output register
  logic                    out_valid_r;
  logic [1:0]              out_mode_r;
  logic [IDX_W-1:0]        out_index_r;
  logic                    out_last_r;
  logic                    out_abort_r;
  logic signed [OFS_W-1:0] out_ofs_r;
  logic [RATE_W-1:0]       out_rate_r;

  // control decode
  logic slot_free, at_cap, test_go, take_stage;
  logic emit_pend, emit_last, emit_abort;

  assign ctrl = hdcp_ucode(step_r);

  assign in_stall   = !ctrl.take_in;
  assign slot_free  = !out_valid_r || !out_stall;
  assign at_cap     = (n_r == IDX_W'(MAX_STAGES));
  // a fitting stage pushes out the previous pending stage, if any
  assign test_go    = (n_r == '0) || slot_free;
  assign take_stage = ctrl.test_en && test_go && !at_cap && fit.hit;
  assign emit_pend  = take_stage && (n_r != '0);
  assign emit_last  = (ctrl.emit == EMIT_LAST) && slot_free;
  assign emit_abort = (ctrl.emit == EMIT_ABORT) && slot_free;

  // setup arithmetic: integer halves scaled into the fixed-point band
  assign rate_half_q = VAL_W'({1'b0, rate_r[RATE_W-1:1]}) << FRAC_BITS;
  assign chan_lo_i   = $signed({cen_r[RATE_W-1], cen_r}) - $signed({2'b00, req_half_r});
  assign chan_hi_i   = $signed({cen_r[RATE_W-1], cen_r}) + $signed({2'b00, req_half_r});
  assign cen_q       = VAL_W'(cen_r) <<< FRAC_BITS;
  assign ofs_ext     = 64'(tmp_r);

  hdcp_halver #(
    .VAL_W(VAL_W)
  ) u_halver (
    .band_lo (lo_r),
    .band_hi (hi_r),
    .band_bw (bw_r),
    .chan_lo (clo_r),
    .chan_hi (chi_r),
    .chan_ok (chan_ok_r),
    .fit     (fit),
    .new_lo  (new_lo),
    .new_hi  (new_hi),
    .new_bw  (new_bw)
  );

  // next step from the condition of the current control word
  always_comb begin
    step_nxt = step_r;
    unique case (ctrl.cond)
      COND_JUMP: begin
        step_nxt = ctrl.tgt;
      end
      COND_IN: begin
        if (in_valid) begin
          step_nxt = step_r + 1'b1;
        end
      end
      COND_RATE0: begin
        step_nxt = (rate_r == '0) ? ctrl.tgt : step_r + 1'b1;
      end
      COND_TEST: begin
        if (test_go && !(fit.hit && !at_cap)) begin
          step_nxt = step_r + 1'b1;
        end
      end
      COND_SLOT: begin
        if (slot_free) begin
          step_nxt = ctrl.tgt;
        end
      end
      default: begin
        step_nxt = STEP_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      n_r         <= '0;
      pend_mode_r <= MODE_NONE;
    end else begin
      step_r <= step_nxt;
      if (ctrl.init_load) begin
        n_r         <= '0;
        pend_mode_r <= MODE_NONE;
      end else if (take_stage) begin
        n_r         <= n_r + 1'b1;
        pend_mode_r <= fit.mode;
      end
    end
  end

  // request capture and band datapath
  always_ff @(posedge clk) begin
    if (ctrl.take_in && in_valid) begin
      rate_r     <= in_input_rate;
      req_half_r <= in_requested_rate[RATE_W-1:1];
      cen_r      <= in_requested_center;
    end
    if (ctrl.init_load) begin
      lo_r      <= -rate_half_q;
      hi_r      <= rate_half_q;
      bw_r      <= rate_half_q << 1;
      clo_r     <= VAL_W'(chan_lo_i) <<< FRAC_BITS;
      chi_r     <= VAL_W'(chan_hi_i) <<< FRAC_BITS;
      // channel band is empty below 2 Hz
      chan_ok_r <= (req_half_r != '0);
    end else if (take_stage) begin
      lo_r <= new_lo;
      hi_r <= new_hi;
      bw_r <= new_bw;
    end
    case (ctrl.alu)
      ALU_MID: tmp_r <= lo_r + $signed(bw_r >> 1);
      ALU_OFS: tmp_r <= cen_q - tmp_r;
      default: tmp_r <= tmp_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_pend || emit_last || emit_abort) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend) begin
      out_mode_r  <= pend_mode_r;
      out_index_r <= n_r - 1'b1;
      out_last_r  <= 1'b0;
      out_abort_r <= 1'b0;
      out_ofs_r   <= '0;
      out_rate_r  <= '0;
    end else if (emit_last) begin
      // with no stage the pending mode is still none
      out_mode_r  <= pend_mode_r;
      out_index_r <= (n_r == '0) ? '0 : n_r - 1'b1;
      out_last_r  <= 1'b1;
      out_abort_r <= 1'b0;
      out_ofs_r   <= ofs_ext[OFS_W-1:0];
      out_rate_r  <= rate_r >> n_r;
    end else if (emit_abort) begin
      out_mode_r  <= MODE_NONE;
      out_index_r <= '0;
      out_last_r  <= 1'b1;
      out_abort_r <= 1'b1;
      out_ofs_r   <= '0;
      out_rate_r  <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stage_mode  = out_mode_r;
  assign out_stage_index = out_index_r;
  assign out_is_last     = out_last_r;
  assign out_aborted     = out_abort_r;
  assign out_offset_q32  = out_ofs_r;
  assign out_output_rate = out_rate_r;

  // stage count never passes the cap
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= IDX_W'(MAX_STAGES))
    else $error("stage count beyond cap");

  // band stays ordered while halving
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_TEST) |-> (lo_r <= hi_r))
    else $error("band edges crossed");

  // an aborted plan is a single last result with no stage
  a_abort: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_abort_r) |-> (out_last_r && out_mode_r == MODE_NONE))
    else $error("abort result malformed");

  // once the last result is loaded the sequencer returns to idle
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_last || emit_abort) |=> (step_r == STEP_IDLE))
    else $error("sequencer did not return to idle");

endmodule
